FILE: rtl/core/mme_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mme_pkg
// Shared constants, word types and helpers of the matrix multiply engine.
// ----------------------------------------------------------------------------
package mme_pkg;

    localparam int MAX_DIM     = 8;
    localparam int DATA_WIDTH  = 32;
    localparam int FRAC_BITS   = 16;
    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;

    localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    localparam int PROD_W    = 2 * DATA_WIDTH;
    localparam int ACC_W_RAW = PROD_W + $clog2(MAX_DIM);
    localparam int ACC_W     = (ACC_W_RAW > DATA_WIDTH + FRAC_BITS + 1) ?
                               ACC_W_RAW : DATA_WIDTH + FRAC_BITS + 1;
    localparam int RND_W     = ACC_W - FRAC_BITS;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0]  REG_ROWS_A     = 2'd0;
    localparam logic [CFG_IDX_W-1:0]  REG_INNER_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0]  REG_COLS_B     = 2'd2;
    localparam logic [CFG_DATA_W-1:0] CFG_RESET      = 4'd8;

    localparam logic KIND_A = 1'b0;
    localparam logic KIND_B = 1'b1;

    typedef struct packed {
        logic              kind;
        logic signed [31:0] value;
    } in_word_t;

    typedef struct packed {
        logic [2:0]         out_row;
        logic [2:0]         out_col;
        logic signed [31:0] product_value;
        logic               saturated;
        logic               last;
    } out_word_t;

    typedef struct packed {
        logic [DIM_W-1:0] m;
        logic [DIM_W-1:0] n;
        logic [DIM_W-1:0] p;
    } dims_t;

    typedef struct packed {
        logic              a_we;
        logic              b_we;
        logic [ADDR_W-1:0] a_waddr;
        logic [ADDR_W-1:0] b_waddr;
        logic [ADDR_W-1:0] a_raddr;
        logic [ADDR_W-1:0] b_raddr;
    } mem_req_t;

    typedef struct packed {
        logic vld;
        logic first;
        logic last;
    } mac_ctl_t;

    typedef struct packed {
        logic                         vld;
        logic signed [DATA_WIDTH-1:0] value;
        logic                         sat;
    } mac_res_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_ISSUE,
        ST_WAIT,
        ST_OUT
    } mme_state_t;

    function automatic logic [DIM_W-1:0] dim_of(input logic [CFG_DATA_W-1:0] r);
        logic [DIM_W-1:0] d;
        if (r == '0) begin
            d = DIM_W'(1);
        end else if (int'(r) > MAX_DIM) begin
            d = DIM_W'(MAX_DIM);
        end else begin
            d = DIM_W'(r);
        end
        return d;
    endfunction

endpackage

FILE: rtl/core/mme_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mme_ram
// Simple dual-port element store, one write and one registered read port.
// ----------------------------------------------------------------------------
module mme_ram
    import mme_pkg::*;
(
    input  logic                  aclk,
    input  logic                  we,
    input  logic [ADDR_W-1:0]     waddr,
    input  logic [DATA_WIDTH-1:0] wdata,
    input  logic [ADDR_W-1:0]     raddr,
    output logic [DATA_WIDTH-1:0] rdata
);

    logic [DATA_WIDTH-1:0] mem [STORE_DEPTH];
    logic [DATA_WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/mme_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mme_mac
// Pipelined multiply-accumulate with round-to-nearest and saturation.
// ----------------------------------------------------------------------------
module mme_mac
    import mme_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  mac_ctl_t              ctl,
    input  logic [DATA_WIDTH-1:0] a_elem,
    input  logic [DATA_WIDTH-1:0] b_elem,
    output mac_res_t              res
);

    localparam logic signed [ACC_W-1:0] HALF =
        {{(ACC_W - FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};
    localparam logic signed [RND_W-1:0] SAT_MAX =
        {{(RND_W - DATA_WIDTH + 1){1'b0}}, {(DATA_WIDTH - 1){1'b1}}};
    localparam logic signed [RND_W-1:0] SAT_MIN = ~SAT_MAX;

    logic signed [PROD_W-1:0] prod_reg;
    mac_ctl_t                 s1_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     s2_done_reg;
    logic signed [ACC_W-1:0]  rsum;
    logic signed [RND_W-1:0]  rnd_reg;
    logic                     s3_vld_reg;
    mac_res_t                 res_reg;
    mac_res_t                 res_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg      <= '0;
            s2_done_reg <= 1'b0;
            s3_vld_reg  <= 1'b0;
            res_reg.vld <= 1'b0;
        end else begin
            s1_reg      <= ctl;
            s2_done_reg <= s1_reg.vld && s1_reg.last;
            s3_vld_reg  <= s2_done_reg;
            res_reg.vld <= res_next.vld;
        end
        res_reg.value <= res_next.value;
        res_reg.sat   <= res_next.sat;
    end

    assign rsum = acc_reg + HALF;

    always_ff @(posedge aclk) begin
        if (ctl.vld) begin
            prod_reg <= $signed(a_elem) * $signed(b_elem);
        end
        if (s1_reg.vld) begin
            if (s1_reg.first) begin
                acc_reg <= ACC_W'(prod_reg);
            end else begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end
        end
        if (s2_done_reg) begin
            rnd_reg <= rsum[ACC_W-1:FRAC_BITS];
        end
    end

    always_comb begin
        res_next.vld = s3_vld_reg;
        if (rnd_reg > SAT_MAX) begin
            res_next.value = SAT_MAX[DATA_WIDTH-1:0];
            res_next.sat   = 1'b1;
        end else if (rnd_reg < SAT_MIN) begin
            res_next.value = SAT_MIN[DATA_WIDTH-1:0];
            res_next.sat   = 1'b1;
        end else begin
            res_next.value = rnd_reg[DATA_WIDTH-1:0];
            res_next.sat   = 1'b0;
        end
    end

    assign res = res_reg;

endmodule

FILE: rtl/core/mme_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mme_ctrl
// Load counters, product sequencer and result word register.
// ----------------------------------------------------------------------------
module mme_ctrl
    import mme_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  dims_t     dims,
    input  logic      s_valid,
    output logic      s_ready,
    input  logic      s_kind,
    output mem_req_t  mem_req,
    output mac_ctl_t  mac_ctl,
    input  mac_res_t  mac_res,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    mme_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  a_count_reg, a_count_next;
    logic [CNT_W-1:0]  b_count_reg, b_count_next;
    logic [IDX_W-1:0]  i_reg, i_next;
    logic [IDX_W-1:0]  j_reg, j_next;
    logic [IDX_W-1:0]  k_reg, k_next;
    logic [ADDR_W-1:0] row_base_reg, row_base_next;
    logic [ADDR_W-1:0] a_addr_reg, a_addr_next;
    logic [ADDR_W-1:0] b_addr_reg, b_addr_next;
    mac_ctl_t          mac_ctl_reg, mac_ctl_next;
    out_word_t         m_data_reg, m_data_next;

    logic [CNT_W-1:0] a_size, b_size;
    logic             accept, a_wr, b_wr, go_calc;
    logic             last_i, last_j, last_k, final_elem, out_done;
    logic             issue;

    assign a_size = CNT_W'(dims.m) * CNT_W'(dims.n);
    assign b_size = CNT_W'(dims.n) * CNT_W'(dims.p);

    assign accept = s_valid && s_ready;
    assign a_wr   = accept && (s_kind == KIND_A) && (a_count_reg < a_size);
    assign b_wr   = accept && (s_kind == KIND_B) && (b_count_reg < b_size);

    assign last_i     = (DIM_W'(i_reg) + DIM_W'(1)) == dims.m;
    assign last_j     = (DIM_W'(j_reg) + DIM_W'(1)) == dims.p;
    assign last_k     = (DIM_W'(k_reg) + DIM_W'(1)) == dims.n;
    assign final_elem = last_i && last_j;
    assign out_done   = m_valid && m_ready;

    assign go_calc = accept &&
                     ((a_count_reg + CNT_W'(a_wr)) >= a_size) &&
                     ((b_count_reg + CNT_W'(b_wr)) >= b_size);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD: begin
                if (go_calc) begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                if (last_k) begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (mac_res.vld) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    state_next = final_elem ? ST_LOAD : ST_ISSUE;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        m_valid = 1'b0;
        issue   = 1'b0;
        case (state_reg)
            ST_LOAD:  s_ready = 1'b1;
            ST_ISSUE: issue   = 1'b1;
            ST_OUT:   m_valid = 1'b1;
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        a_count_next  = a_count_reg + CNT_W'(a_wr);
        b_count_next  = b_count_reg + CNT_W'(b_wr);
        i_next        = i_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        row_base_next = row_base_reg;
        a_addr_next   = a_addr_reg;
        b_addr_next   = b_addr_reg;
        m_data_next   = m_data_reg;

        mac_ctl_next.vld   = issue;
        mac_ctl_next.first = (k_reg == '0);
        mac_ctl_next.last  = last_k;

        if (go_calc && (state_reg == ST_LOAD)) begin
            i_next        = '0;
            j_next        = '0;
            k_next        = '0;
            row_base_next = '0;
            a_addr_next   = '0;
            b_addr_next   = '0;
        end

        if (issue && !last_k) begin
            k_next      = k_reg + IDX_W'(1);
            a_addr_next = a_addr_reg + ADDR_W'(1);
            b_addr_next = b_addr_reg + ADDR_W'(dims.p);
        end

        if ((state_reg == ST_WAIT) && mac_res.vld) begin
            m_data_next.out_row       = 3'(i_reg);
            m_data_next.out_col       = 3'(j_reg);
            m_data_next.product_value = 32'($signed(mac_res.value));
            m_data_next.saturated     = mac_res.sat;
            m_data_next.last          = final_elem;
        end

        if (out_done) begin
            k_next = '0;
            if (final_elem) begin
                a_count_next = '0;
                b_count_next = '0;
            end else if (last_j) begin
                i_next        = i_reg + IDX_W'(1);
                j_next        = '0;
                row_base_next = row_base_reg + ADDR_W'(dims.n);
                a_addr_next   = row_base_reg + ADDR_W'(dims.n);
                b_addr_next   = '0;
            end else begin
                j_next      = j_reg + IDX_W'(1);
                a_addr_next = row_base_reg;
                b_addr_next = ADDR_W'(j_reg) + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            a_count_reg <= '0;
            b_count_reg <= '0;
            mac_ctl_reg <= '0;
        end else begin
            state_reg   <= state_next;
            a_count_reg <= a_count_next;
            b_count_reg <= b_count_next;
            mac_ctl_reg <= mac_ctl_next;
        end
    end

    always_ff @(posedge aclk) begin
        i_reg        <= i_next;
        j_reg        <= j_next;
        k_reg        <= k_next;
        row_base_reg <= row_base_next;
        a_addr_reg   <= a_addr_next;
        b_addr_reg   <= b_addr_next;
        m_data_reg   <= m_data_next;
    end

    assign mem_req.a_we    = a_wr;
    assign mem_req.b_we    = b_wr;
    assign mem_req.a_waddr = a_count_reg[ADDR_W-1:0];
    assign mem_req.b_waddr = b_count_reg[ADDR_W-1:0];
    assign mem_req.a_raddr = a_addr_reg;
    assign mem_req.b_raddr = b_addr_reg;
    assign mac_ctl         = mac_ctl_reg;
    assign m_data          = m_data_reg;

    a_no_load_while_out: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input open while a result word is pending");

    a_res_only_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        mac_res.vld |-> (state_reg == ST_WAIT))
        else $error("accumulator result outside wait state");

    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_data.last) |=>
        (state_reg == ST_LOAD && a_count_reg == '0 && b_count_reg == '0))
        else $error("load counters not cleared after final word");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (int'(a_count_reg) <= STORE_DEPTH) && (int'(b_count_reg) <= STORE_DEPTH))
        else $error("load counter past store depth");

endmodule

FILE: rtl/core/matrix_multiply_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_multiply_engine
// Loads A and B in row-major order, then streams C = A * B (Q16.16, rounded,
// saturated) in row-major order with a last flag.
//
//   channel   dir   signals                       word
//   s_        in    s_valid s_ready s_data        in_word_t (kind, value)
//   m_        out   m_valid m_ready m_data        out_word_t
//   cfg_      in    cfg_valid cfg_ready cfg_index cfg_data (4-bit register)
//
// Load words are accepted one per cycle; s_ready is low while C is produced.
// Each C element takes inner_size store reads, then passes through the
// multiply-accumulate pipeline and result register, plus any m_ready wait.
// One shared multiplier reading one entry of each store per cycle sets this.
// Reset is synchronous; sizes return to 8 and load counters to zero.
// No clearing pass: stores hold undefined data until loaded.
// ----------------------------------------------------------------------------
module matrix_multiply_engine
    import mme_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_word_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_word_t             m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [CFG_DATA_W-1:0] rows_a_reg, inner_size_reg, cols_b_reg;
    dims_t                 dims;
    mem_req_t              mem_req;
    mac_ctl_t              mac_ctl;
    mac_res_t              mac_res;
    logic [DATA_WIDTH-1:0] elem;
    logic [DATA_WIDTH-1:0] a_rdata, b_rdata;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_a_reg     <= CFG_RESET;
            inner_size_reg <= CFG_RESET;
            cols_b_reg     <= CFG_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_ROWS_A:     rows_a_reg     <= cfg_data;
                REG_INNER_SIZE: inner_size_reg <= cfg_data;
                REG_COLS_B:     cols_b_reg     <= cfg_data;
                default: begin
                    rows_a_reg <= rows_a_reg;
                end
            endcase
        end
    end

    assign dims.m = dim_of(rows_a_reg);
    assign dims.n = dim_of(inner_size_reg);
    assign dims.p = dim_of(cols_b_reg);

    assign elem = s_data.value[DATA_WIDTH-1:0];

    mme_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .dims    (dims),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_kind  (s_data.kind),
        .mem_req (mem_req),
        .mac_ctl (mac_ctl),
        .mac_res (mac_res),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    mme_ram u_a_store (
        .aclk  (aclk),
        .we    (mem_req.a_we),
        .waddr (mem_req.a_waddr),
        .wdata (elem),
        .raddr (mem_req.a_raddr),
        .rdata (a_rdata)
    );

    mme_ram u_b_store (
        .aclk  (aclk),
        .we    (mem_req.b_we),
        .waddr (mem_req.b_waddr),
        .wdata (elem),
        .raddr (mem_req.b_raddr),
        .rdata (b_rdata)
    );

    mme_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mac_ctl),
        .a_elem  (a_rdata),
        .b_elem  (b_rdata),
        .res     (mac_res)
    );

endmodule

FILE: tb/sv/mme_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mme_checker
// Watches the config, load and result channels of the matrix multiply engine.
// It keeps its own copy of the size registers and of both element stores, and
// works out C = A * B (exact sum, round half up, saturate) whenever both
// matrices are complete. Each result word is then compared field by field
// with the oldest predicted element of C.
// ----------------------------------------------------------------------------
module mme_checker
    import mme_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  in_word_t              s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  out_word_t             m_data,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending
);

    localparam logic signed [79:0] Q_MAX = 80'sh7FFF_FFFF;
    localparam logic signed [79:0] Q_MIN = -80'sh8000_0000;

    logic [CFG_DATA_W-1:0] rows_reg;
    logic [CFG_DATA_W-1:0] inner_reg;
    logic [CFG_DATA_W-1:0] cols_reg;
    logic signed [31:0]    a_mem [STORE_DEPTH];
    logic signed [31:0]    b_mem [STORE_DEPTH];
    int                    a_cnt;
    int                    b_cnt;
    int                    fails = 0;
    out_word_t             c_expected [$];

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    function automatic int dim_size(input logic [CFG_DATA_W-1:0] r);
        if (r == '0) begin
            return 1;
        end
        if (int'(r) > MAX_DIM) begin
            return MAX_DIM;
        end
        return int'(r);
    endfunction

    function automatic void predict_product(input int m, input int n, input int p);
        logic signed [79:0] acc;
        logic signed [63:0] prod;
        logic signed [79:0] rnd;
        out_word_t          w;
        for (int i = 0; i < m; i++) begin
            for (int j = 0; j < p; j++) begin
                acc = '0;
                for (int k = 0; k < n; k++) begin
                    prod = a_mem[i * n + k] * b_mem[k * p + j];
                    acc += prod;
                end
                rnd = (acc + 80'sd32768) >>> FRAC_BITS;
                w.saturated = 1'b0;
                if (rnd > Q_MAX) begin
                    rnd = Q_MAX;
                    w.saturated = 1'b1;
                end else if (rnd < Q_MIN) begin
                    rnd = Q_MIN;
                    w.saturated = 1'b1;
                end
                w.out_row       = 3'(i);
                w.out_col       = 3'(j);
                w.product_value = rnd[31:0];
                w.last          = (i == m - 1) && (j == p - 1);
                c_expected.push_back(w);
            end
        end
    endfunction

    always @(posedge aclk) begin
        out_word_t want;
        int        m;
        int        n;
        int        p;
        if (!aresetn) begin
            rows_reg  = CFG_RESET;
            inner_reg = CFG_RESET;
            cols_reg  = CFG_RESET;
            a_cnt     = 0;
            b_cnt     = 0;
            c_expected.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_ROWS_A:     rows_reg  = cfg_data;
                    REG_INNER_SIZE: inner_reg = cfg_data;
                    REG_COLS_B:     cols_reg  = cfg_data;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (c_expected.size() == 0) begin
                    if (fails < 10) begin
                        $display("unexpected word: row %0d col %0d value %h sat %b last %b",
                                 m_data.out_row, m_data.out_col, m_data.product_value,
                                 m_data.saturated, m_data.last);
                    end
                    fails++;
                end else begin
                    want = c_expected.pop_front();
                    if (m_data.out_row !== want.out_row || m_data.out_col !== want.out_col ||
                        m_data.product_value !== want.product_value ||
                        m_data.saturated !== want.saturated || m_data.last !== want.last) begin
                        if (fails < 10) begin
                            $display("mismatch C[%0d][%0d]: exp value %h sat %b last %b, got row %0d col %0d value %h sat %b last %b",
                                     want.out_row, want.out_col, want.product_value,
                                     want.saturated, want.last, m_data.out_row,
                                     m_data.out_col, m_data.product_value,
                                     m_data.saturated, m_data.last);
                        end
                        fails++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                m = dim_size(rows_reg);
                n = dim_size(inner_reg);
                p = dim_size(cols_reg);
                if (s_data.kind == KIND_A) begin
                    if (a_cnt < m * n) begin
                        a_mem[a_cnt] = s_data.value;
                        a_cnt++;
                    end
                end else begin
                    if (b_cnt < n * p) begin
                        b_mem[b_cnt] = s_data.value;
                        b_cnt++;
                    end
                end
                if (a_cnt >= m * n && b_cnt >= n * p) begin
                    predict_product(m, n, p);
                    a_cnt = 0;
                    b_cnt = 0;
                end
            end
        end
        fail_count <= fails;
        pending    <= c_expected.size();
    end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the matrix multiply engine. A directed part covers
// value extremes, saturation both ways, rounding ties, out-of-range sizes,
// excess elements, an unused register index and a size change during a load.
// Random jobs follow with mostly small sizes, bursty loads and a stalling
// result sink, including one long back-pressure stretch.
// ----------------------------------------------------------------------------
module tb_top
    import mme_pkg::*;
();

    localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_word_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_word_t             m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  stall_req = 1'b0;
    int                    fail_count;
    int                    pending;
    int                    burst_left = 0;
    int                    items_sent = 0;

    always #2 aclk = ~aclk;

    matrix_multiply_engine uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    mme_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 5))
                    0:       v = 32'h7FFF_FFFF;
                    1:       v = 32'h8000_0000;
                    2:       v = 32'h0000_0000;
                    3:       v = 32'hFFFF_FFFF;
                    4:       v = 32'h0000_8000;
                    default: v = 32'h0001_0000;
                endcase
            end
            1, 2, 3: v = $urandom;
            4, 5, 6, 7: v = 32'($urandom_range(0, 32'h7_FFFF)) - 32'h4_0000;
            default: v = 32'($urandom_range(0, 32'h1_FFFF)) - 32'h1_0000;
        endcase
        return v;
    endfunction

    function automatic int pick_dim();
        if ($urandom_range(0, 5) == 0) begin
            return $urandom_range(5, MAX_DIM);
        end
        return $urandom_range(1, 4);
    endfunction

    // sizes 1 and MAX_DIM also go out as their out-of-range aliases
    function automatic logic [CFG_DATA_W-1:0] reg_code(input int dim);
        if (dim == 1 && $urandom_range(0, 2) == 0) begin
            return '0;
        end
        if (dim == MAX_DIM && $urandom_range(0, 1) == 0) begin
            return CFG_DATA_W'($urandom_range(MAX_DIM + 1, 15));
        end
        return CFG_DATA_W'(dim);
    endfunction

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic set_sizes(input logic [CFG_DATA_W-1:0] rows, input logic [CFG_DATA_W-1:0] inner,
                             input logic [CFG_DATA_W-1:0] cols, input logic with_unused);
        cfg_write(REG_ROWS_A, rows);
        if (with_unused) begin
            cfg_write(REG_NONE, CFG_DATA_W'($urandom));
        end
        cfg_write(REG_INNER_SIZE, inner);
        cfg_write(REG_COLS_B, cols);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_word(input logic kind, input logic [31:0] value);
        in_word_t w;
        int       gap;
        w.kind  = kind;
        w.value = value;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (32) @(posedge aclk);
    endtask

    // one full load of A and B, interleaved at random; a finished matrix
    // sometimes gets an excess element while the other is still loading
    task automatic run_job(input int m, input int n, input int p);
        int   a_left;
        int   b_left;
        logic k;
        a_left = m * n;
        b_left = n * p;
        while (a_left + b_left > 0) begin
            if (a_left == 0 && $urandom_range(0, 15) == 0) begin
                send_word(KIND_A, pick_value());
            end else if (b_left == 0 && $urandom_range(0, 15) == 0) begin
                send_word(KIND_B, pick_value());
            end else begin
                k = ($urandom_range(1, a_left + b_left) <= a_left) ? KIND_A : KIND_B;
                send_word(k, pick_value());
                if (k == KIND_A) begin
                    a_left--;
                end else begin
                    b_left--;
                end
                items_sent++;
            end
        end
    endtask

    initial begin : result_sink
        int   mode;
        int   span;
        logic hold_done;
        hold_done = 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 60);
            for (int c = 0; c < span; c++) begin
                @(posedge aclk);
                if (stall_req && !hold_done) begin
                    hold_done = 1'b1;
                    m_ready <= 1'b0;
                    repeat (400) @(posedge aclk);
                end
                case (mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= 1'($urandom_range(0, 1));
                    2:       m_ready <= ($urandom_range(0, 7) != 0);
                    default: m_ready <= ((c % 5) >= 2);
                endcase
            end
        end
    end

    initial begin : stimulus
        int m;
        int n;
        int p;
        int jobs;
        int phase;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // 1x1 times 1x2, saturating both ways; second A word is excess
        set_sizes(4'd0, 4'd1, 4'd2, 1'b0);
        send_word(KIND_A, 32'h7FFF_FFFF);
        send_word(KIND_A, 32'h1234_5678);
        send_word(KIND_B, 32'h7FFF_FFFF);
        send_word(KIND_B, 32'h8000_0000);
        wait_drained();

        // rounding ties at +/- half an LSB
        set_sizes(4'd2, 4'd1, 4'd1, 1'b1);
        send_word(KIND_B, 32'h0000_8000);
        send_word(KIND_A, 32'h0000_0001);
        send_word(KIND_A, 32'hFFFF_FFFF);
        wait_drained();

        set_sizes(4'd1, 4'd2, 4'd1, 1'b0);
        send_word(KIND_A, 32'h8000_0000);
        send_word(KIND_B, 32'h8000_0000);
        send_word(KIND_A, 32'h0000_0000);
        send_word(KIND_B, 32'h7FFF_FFFF);
        wait_drained();

        // partial load at full size, then shrink; next word is dropped but completes
        set_sizes(4'd15, 4'd9, 4'd8, 1'b0);
        repeat (6) send_word(KIND_A, pick_value());
        repeat (4) send_word(KIND_B, pick_value());
        wait_drained();
        set_sizes(4'd1, 4'd2, 4'd2, 1'b0);
        send_word(KIND_A, pick_value());
        wait_drained();

        items_sent = 0;
        set_sizes(reg_code(MAX_DIM), reg_code(MAX_DIM), reg_code(MAX_DIM), 1'b0);
        run_job(MAX_DIM, MAX_DIM, MAX_DIM);
        wait_drained();

        phase = 0;
        while (items_sent < 380 || phase < 2) begin
            if (phase == 1) begin
                m    = 4;
                n    = 2;
                p    = 4;
                jobs = 3;
            end else begin
                m    = pick_dim();
                n    = pick_dim();
                p    = pick_dim();
                jobs = $urandom_range(1, 3);
            end
            set_sizes(reg_code(m), reg_code(n), reg_code(p), ($urandom_range(0, 7) == 0));
            if (phase == 1) begin
                stall_req <= 1'b1;
            end
            repeat (jobs) run_job(m, n, p);
            wait_drained();
            phase++;
        end

        repeat (32) @(posedge aclk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: matrix_multiply_engine.f
rtl/core/mme_pkg.sv
rtl/core/mme_ram.sv
rtl/core/mme_mac.sv
rtl/core/mme_ctrl.sv
rtl/core/matrix_multiply_engine.sv
tb/sv/mme_checker.sv
tb/sv/tb_top.sv
